/* src/tlb_pkg.sv */
// ----------------------------------------------------------------------------
// tlb_pkg
// Shared types and constants for the LRU translation cache.
// ----------------------------------------------------------------------------
package tlb_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int DATA_W      = 32;
  localparam int CAP_W       = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_TOUCH  = 2'd1,
    OP_INSERT = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] page;
    logic [DATA_W-1:0] frame;
    logic [DATA_W-1:0] address;
    logic              walk_flag;
  } tlb_entry_t;

  typedef struct packed {
    logic clear;
    logic cmp_en;
  } scan_ctl_t;

  typedef struct packed {
    logic match;
    logic free_found;
    logic oldest_found;
  } scan_flags_t;

endpackage

/* src/tlb_mem.sv */
// ----------------------------------------------------------------------------
// tlb_mem
// Entry store: mapping fields and recency stamps, one read and one write
// port each, registered read data.
// ----------------------------------------------------------------------------
module tlb_mem
  import tlb_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int IDX_W   = 4
) (
  input  logic              clk,
  input  logic [IDX_W-1:0]  rd_addr,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic              wr_entry_en,
  input  logic              wr_stamp_en,
  input  tlb_entry_t        wr_entry,
  input  logic [DATA_W-1:0] wr_stamp,
  output tlb_entry_t        rd_entry_r,
  output logic [DATA_W-1:0] rd_stamp_r
);

  tlb_entry_t        entry_mem_r [ENTRIES];
  logic [DATA_W-1:0] stamp_mem_r [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_entry_en) begin
      entry_mem_r[wr_addr] <= wr_entry;
    end
    rd_entry_r <= entry_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_stamp_en) begin
      stamp_mem_r[wr_addr] <= wr_stamp;
    end
    rd_stamp_r <= stamp_mem_r[rd_addr];
  end

endmodule

/* src/tlb_scan.sv */
// ----------------------------------------------------------------------------
// tlb_scan
// Compare unit stepped over the entries one per cycle: page match, valid
// count, first free entry and oldest stamp.
// ----------------------------------------------------------------------------
module tlb_scan
  import tlb_pkg::*;
#(
  parameter int IDX_W   = 4,
  parameter int CNT_W   = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  scan_ctl_t         ctl,
  input  logic [IDX_W-1:0]  cmp_idx,
  input  logic              cmp_valid,
  input  logic [DATA_W-1:0] key_page,
  input  tlb_entry_t        rd_entry,
  input  logic [DATA_W-1:0] rd_stamp,
  output scan_flags_t       flags_r,
  output logic [IDX_W-1:0]  match_idx_r,
  output tlb_entry_t        match_entry_r,
  output logic [CNT_W-1:0]  count_r,
  output logic [IDX_W-1:0]  free_idx_r,
  output logic [IDX_W-1:0]  victim_idx_r,
  output logic [DATA_W-1:0] victim_page_r
);

  scan_flags_t       flags_nxt;
  logic [IDX_W-1:0]  match_idx_nxt;
  tlb_entry_t        match_entry_nxt;
  logic [CNT_W-1:0]  count_nxt;
  logic [IDX_W-1:0]  free_idx_nxt;
  logic [IDX_W-1:0]  victim_idx_nxt;
  logic [DATA_W-1:0] victim_page_nxt;
  logic [DATA_W-1:0] victim_stamp_r;
  logic [DATA_W-1:0] victim_stamp_nxt;

  always_comb begin
    flags_nxt        = flags_r;
    match_idx_nxt    = match_idx_r;
    match_entry_nxt  = match_entry_r;
    count_nxt        = count_r;
    free_idx_nxt     = free_idx_r;
    victim_idx_nxt   = victim_idx_r;
    victim_page_nxt  = victim_page_r;
    victim_stamp_nxt = victim_stamp_r;
    if (ctl.clear) begin
      flags_nxt = '0;
      count_nxt = '0;
    end else if (ctl.cmp_en) begin
      if (cmp_valid) begin
        count_nxt = count_r + CNT_W'(1);
        if (!flags_r.match && rd_entry.page == key_page) begin
          flags_nxt.match = 1'b1;
          match_idx_nxt   = cmp_idx;
          match_entry_nxt = rd_entry;
        end
        if (!flags_r.oldest_found || rd_stamp < victim_stamp_r) begin
          flags_nxt.oldest_found = 1'b1;
          victim_idx_nxt   = cmp_idx;
          victim_page_nxt  = rd_entry.page;
          victim_stamp_nxt = rd_stamp;
        end
      end else if (!flags_r.free_found) begin
        flags_nxt.free_found = 1'b1;
        free_idx_nxt = cmp_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      count_r <= '0;
    end else begin
      flags_r <= flags_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    match_idx_r    <= match_idx_nxt;
    match_entry_r  <= match_entry_nxt;
    free_idx_r     <= free_idx_nxt;
    victim_idx_r   <= victim_idx_nxt;
    victim_page_r  <= victim_page_nxt;
    victim_stamp_r <= victim_stamp_nxt;
  end

endmodule

/* src/tlb_lru_cache.sv */
// ----------------------------------------------------------------------------
// tlb_lru_cache
// Fully associative translation cache with least-recently-used replacement.
//
// Input channel: an item (in_op, page number, time, address, frame, flag) is
// taken when start is high and busy is low. busy stays high until the item's
// result has been computed and any entry update done.
// Ops: lookup reports a stored mapping, touch restamps and reports a present
// entry, insert writes a mapping, in place, into a free entry, or over the
// entry with the oldest stamp once the valid count reaches the capacity.
// Result channel: one result per item, shown for one cycle with out_valid.
// The receiver cannot stall; each result must be taken when shown.
// Config: cfg_valid/cfg_ready writes the 5-bit capacity; cfg_ready is always
// high. Write it only while the block is idle.
// Timing: one entry is compared per cycle through a registered memory read;
// the scan, a drain state and a final update state keep busy high, and the
// result is shown in the first cycle in which busy is low again. A new item
// may be started in the cycle its predecessor's result is shown.
// Reset: rst_n (synchronous) clears all valid bits and sets capacity to 16.
// ----------------------------------------------------------------------------
module tlb_lru_cache
  import tlb_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_op,
  input  logic [DATA_W-1:0] in_page_number,
  input  logic [DATA_W-1:0] in_access_time,
  input  logic [DATA_W-1:0] in_full_address,
  input  logic [DATA_W-1:0] in_frame_number,
  input  logic              in_walk_hit,
  output logic              out_valid,
  output logic              out_hit,
  output logic [DATA_W-1:0] out_frame,
  output logic [DATA_W-1:0] out_address,
  output logic              out_walk_hit,
  output logic              out_evicted,
  output logic [DATA_W-1:0] out_evicted_page,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic [ENTRIES-1:0] valid_r;
  logic [CAP_W-1:0]  cap_r;

  op_t               op_r;
  logic [DATA_W-1:0] page_r, time_r, addr_r, frame_r;
  logic              flag_r;

  logic              accept;
  scan_ctl_t         scan_ctl;
  tlb_entry_t        rd_entry;
  logic [DATA_W-1:0] rd_stamp;
  scan_flags_t       flags;
  logic [IDX_W-1:0]  match_idx, free_idx, victim_idx;
  tlb_entry_t        match_entry;
  logic [CNT_W-1:0]  count;
  logic [DATA_W-1:0] victim_page;

  logic [CW-1:0]     cap_ext, eff_cap;
  logic              need_evict;
  logic [IDX_W-1:0]  target;
  logic              wr_entry_en, wr_stamp_en;
  tlb_entry_t        wr_entry;

  logic              out_valid_r;
  logic              out_hit_r, out_hit_nxt;
  logic [DATA_W-1:0] out_frame_r, out_frame_nxt;
  logic [DATA_W-1:0] out_address_r, out_address_nxt;
  logic              out_walk_hit_r, out_walk_hit_nxt;
  logic              out_evicted_r, out_evicted_nxt;
  logic [DATA_W-1:0] out_evicted_page_r, out_evicted_page_nxt;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    rd_idx_nxt = rd_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        rd_idx_nxt = '0;
        if (accept) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          rd_idx_nxt = rd_idx_r + IDX_W'(1);
        end
      end
      ST_DRAIN: state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    scan_ctl.clear  = accept;
    scan_ctl.cmp_en = cmp_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
      cap_r     <= CAP_RESET;
      valid_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_idx_r  <= rd_idx_nxt;
      cmp_vld_r <= (state_r == ST_SCAN);
      out_valid_r <= (state_r == ST_FIN);
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (wr_entry_en) begin
        valid_r[target] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= rd_idx_r;
    if (accept) begin
      op_r    <= op_t'(in_op);
      page_r  <= in_page_number;
      time_r  <= in_access_time;
      addr_r  <= in_full_address;
      frame_r <= in_frame_number;
      flag_r  <= in_walk_hit;
    end
  end

  tlb_mem #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_mem (
    .clk         (clk),
    .rd_addr     (rd_idx_r),
    .wr_addr     (target),
    .wr_entry_en (wr_entry_en),
    .wr_stamp_en (wr_stamp_en),
    .wr_entry    (wr_entry),
    .wr_stamp    (time_r),
    .rd_entry_r  (rd_entry),
    .rd_stamp_r  (rd_stamp)
  );

  tlb_scan #(
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (scan_ctl),
    .cmp_idx       (cmp_idx_r),
    .cmp_valid     (valid_r[cmp_idx_r]),
    .key_page      (page_r),
    .rd_entry      (rd_entry),
    .rd_stamp      (rd_stamp),
    .flags_r       (flags),
    .match_idx_r   (match_idx),
    .match_entry_r (match_entry),
    .count_r       (count),
    .free_idx_r    (free_idx),
    .victim_idx_r  (victim_idx),
    .victim_page_r (victim_page)
  );

  // replacement decision
  always_comb begin
    cap_ext = CW'(cap_r);
    if (cap_r == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    need_evict = (CW'(count) >= eff_cap) || !flags.free_found;
    priority if (flags.match) begin
      target = match_idx;
    end else if (need_evict) begin
      target = flags.oldest_found ? victim_idx : '0;
    end else begin
      target = free_idx;
    end
    wr_entry.page      = page_r;
    wr_entry.frame     = frame_r;
    wr_entry.address   = addr_r;
    wr_entry.walk_flag = flag_r;
    wr_entry_en = (state_r == ST_FIN) && (op_r == OP_INSERT);
    wr_stamp_en = (state_r == ST_FIN) &&
                  ((op_r == OP_INSERT) || ((op_r == OP_TOUCH) && flags.match));
  end

  // result
  always_comb begin
    out_hit_nxt          = 1'b0;
    out_frame_nxt        = '0;
    out_address_nxt      = '0;
    out_walk_hit_nxt     = 1'b0;
    out_evicted_nxt      = 1'b0;
    out_evicted_page_nxt = '0;
    unique case (op_r)
      OP_LOOKUP, OP_TOUCH: begin
        if (flags.match) begin
          out_hit_nxt      = 1'b1;
          out_frame_nxt    = match_entry.frame;
          out_address_nxt  = match_entry.address;
          out_walk_hit_nxt = match_entry.walk_flag;
        end
      end
      OP_INSERT: begin
        out_hit_nxt      = flags.match;
        out_frame_nxt    = frame_r;
        out_address_nxt  = addr_r;
        out_walk_hit_nxt = flag_r;
        if (!flags.match && need_evict && flags.oldest_found) begin
          out_evicted_nxt      = 1'b1;
          out_evicted_page_nxt = victim_page;
        end
      end
      OP_RSVD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN) begin
      out_hit_r          <= out_hit_nxt;
      out_frame_r        <= out_frame_nxt;
      out_address_r      <= out_address_nxt;
      out_walk_hit_r     <= out_walk_hit_nxt;
      out_evicted_r      <= out_evicted_nxt;
      out_evicted_page_r <= out_evicted_page_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_frame        = out_frame_r;
  assign out_address      = out_address_r;
  assign out_walk_hit     = out_walk_hit_r;
  assign out_evicted      = out_evicted_r;
  assign out_evicted_page = out_evicted_page_r;

  a_strobe_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_FIN))
    else $error("result strobe without a finished item");

  a_start_scans: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_SCAN) && (rd_idx_r == '0))
    else $error("accepted item did not start a scan");

  a_evict_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_evicted_r) |-> !out_hit_r)
    else $error("eviction reported on a hit");

  a_valid_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_FIN) |=> (valid_r == $past(valid_r)))
    else $error("valid bits changed outside the update cycle");

endmodule
